// ===== sv/mep_pkg.sv =====
// ----------------------------------------------------------------------------
// mep_pkg
// Shared constants for the Mandelbrot escape-time pixel block.
// ----------------------------------------------------------------------------
`default_nettype none

package mep_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_REG_W  = 13;
    localparam int ITER_W     = 16;
    localparam int PIX_W      = 12;
    localparam int SHADE_W    = 8;
    localparam int NUM_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 2'd2;

    localparam logic [DIM_REG_W-1:0] RST_IMAGE_WIDTH    = 13'd640;
    localparam logic [DIM_REG_W-1:0] RST_IMAGE_HEIGHT   = 13'd480;
    localparam logic [ITER_W-1:0]    RST_MAX_ITERATIONS = 16'd256;

    localparam logic [SHADE_W-1:0] SHADE_ESCAPED = 8'hFF;
    localparam logic [SHADE_W-1:0] SHADE_INSIDE  = 8'hFF - 8'h33;

endpackage

`default_nettype wire

// ===== sv/mandelbrot_escape_pixel.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel
// Maps a pixel onto the complex plane and runs the escape-time iteration
// z = z*z + c in Q4 fixed point on one shared half-width multiplier.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data    | in
//  pixel    | in_valid in_ready pixel_column pixel_row  | in
//  result   | out_valid out_ready shade in_set          | out
//
//  Per pixel two bit-serial divisions run first, then each of the k steps
//  taken (up to max_iterations) forms three products on the shared
//  multiplier, and a final escape test ends the pixel. One pixel in flight;
//  in_ready is high only while idle. A finished result waits in the output
//  register while the next pixel runs. Reset is asynchronous and restores
//  the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_pixel
    import mep_pkg::*;
#(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 28
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [PIX_W-1:0]      pixel_column,
    input  wire logic [PIX_W-1:0]      pixel_row,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic [SHADE_W-1:0]    shade,
    output      logic                  in_set
);

    localparam int W   = FRAC_BITS + 4;
    localparam int W1  = W + 1;
    localparam int W2  = W + 2;
    localparam int HW  = (W + 1) / 2;
    localparam int MW  = 2 * HW;
    localparam int PW  = 4 * HW;
    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int QW  = FRAC_BITS + 6;
    localparam int QS  = QW + 1;
    localparam int CW  = $clog2(FRAC_BITS + 16);

    localparam logic [CW-1:0] LAST_RE = CW'(FRAC_BITS + 14);
    localparam logic [CW-1:0] LAST_IM = CW'(FRAC_BITS + 15);

    localparam logic [QW-1:0] QUO_CAP  = QW'(1) << (FRAC_BITS + 5);
    localparam logic [QS-1:0] QUO_CAPX = QS'(1) << (FRAC_BITS + 5);

    localparam logic signed [QS-1:0] MAP_HALF5 = QS'(5) << (FRAC_BITS - 1);
    localparam logic signed [QS-1:0] MAP_ONE   = QS'(1) << FRAC_BITS;
    localparam logic signed [QS-1:0] MAP_MAX   = {4'b0000, {(W-1){1'b1}}};

    localparam logic [W1-1:0] ESC_FOUR = W1'(4) << FRAC_BITS;

    localparam logic signed [W2-1:0] ZMAX2 = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W2-1:0] ZMIN2 = {3'b111, {(W-1){1'b0}}};
    localparam logic signed [W1-1:0] ZMAX1 = {2'b00, {(W-1){1'b1}}};
    localparam logic signed [W1-1:0] ZMIN1 = {2'b11, {(W-1){1'b0}}};

    localparam logic [PW-1:0] MASK_SQ = (PW'(1) << FRAC_BITS) - PW'(1);
    localparam logic [PW-1:0] MASK_RI = (PW'(1) << (FRAC_BITS - 1)) - PW'(1);
    localparam logic [PW-1:0] LIM_POS = (PW'(1) << (W - 1)) - PW'(1);
    localparam logic [PW-1:0] LIM_NEG = PW'(1) << (W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MAP,
        S_MUL,
        S_FIN,
        S_CHECK,
        S_UPDATE,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_RR,
        OP_II,
        OP_RI
    } mul_op_t;

    state_t                 state_reg;
    mul_op_t                op_reg;
    logic [2:0]             ph_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   im_sel_reg;
    logic [ITER_W-1:0]      k_reg;
    logic                   inside_reg;
    logic                   out_valid_reg;
    logic [SHADE_W-1:0]     shade_reg;
    logic                   in_set_reg;
    logic [DIM_REG_W-1:0]   width_reg;
    logic [DIM_REG_W-1:0]   height_reg;
    logic [ITER_W-1:0]      max_iter_reg;

    logic [NUM_W-1:0]       num_reg;
    logic [DW-1:0]          div_reg;
    logic [DW-1:0]          rem_reg;
    logic [QW-1:0]          quo_reg;
    logic [PIX_W-1:0]       row_reg;
    logic signed [W-1:0]    cr_reg;
    logic signed [W-1:0]    ci_reg;
    logic signed [W-1:0]    zr_reg;
    logic signed [W-1:0]    zi_reg;
    logic signed [W-1:0]    rr_reg;
    logic signed [W-1:0]    ii_reg;
    logic signed [W-1:0]    ri_reg;
    logic [MW-1:0]          ma_reg;
    logic [MW-1:0]          mb_reg;
    logic                   neg_reg;
    logic [MW-1:0]          prod_reg;
    logic [PW-1:0]          acc_reg;

    logic [DW-1:0]          eff_w;
    logic [DW-1:0]          eff_h;
    logic [DW:0]            rem_try;
    logic                   rem_ge;
    logic [DW-1:0]          rem_new;
    logic [QS-1:0]          quo_try;
    logic [QW-1:0]          quo_new;
    logic signed [QS-1:0]   map_diff;
    logic signed [W-1:0]    map_res;
    logic signed [W-1:0]    opa;
    logic signed [W-1:0]    opb;
    logic [W-1:0]           mag_a;
    logic [W-1:0]           mag_b;
    logic [1:0]             part_mul;
    logic [1:0]             part_acc;
    logic [HW-1:0]          fac_a;
    logic [HW-1:0]          fac_b;
    logic [MW-1:0]          prod_new;
    logic [PW-1:0]          acc_add;
    logic [PW-1:0]          q_floor;
    logic                   rem_nz;
    logic [PW-1:0]          q_mag;
    logic [PW-1:0]          q_lim;
    logic [PW-1:0]          q_sat;
    logic signed [W-1:0]    fin_res;
    logic [W1-1:0]          mag_sum;
    logic                   escaped;
    logic signed [W2-1:0]   zr_wide;
    logic signed [W1-1:0]   zi_wide;
    logic signed [W-1:0]    zr_new;
    logic signed [W-1:0]    zi_new;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign shade     = shade_reg;
    assign in_set    = in_set_reg;

    // effective dimensions: zero acts as one, clamp at MAX_DIM
    always_comb
    begin
        if (width_reg == '0)
            eff_w = DW'(1);
        else if (32'(width_reg) > 32'(MAX_DIM))
            eff_w = DW'(MAX_DIM);
        else
            eff_w = DW'(width_reg);

        if (height_reg == '0)
            eff_h = DW'(1);
        else if (32'(height_reg) > 32'(MAX_DIM))
            eff_h = DW'(MAX_DIM);
        else
            eff_h = DW'(height_reg);
    end

    // restoring divider, one quotient bit per cycle
    always_comb
    begin
        rem_try = {rem_reg, num_reg[NUM_W-1]};
        rem_ge  = (rem_try >= {1'b0, div_reg});
        rem_new = rem_ge ? DW'(rem_try - {1'b0, div_reg}) : DW'(rem_try);
        quo_try = {quo_reg, rem_ge};
        quo_new = (quo_try > QUO_CAPX) ? QUO_CAP : quo_try[QW-1:0];
    end

    always_comb
    begin
        map_diff = $signed({1'b0, quo_reg}) - (im_sel_reg ? MAP_ONE : MAP_HALF5);
        map_res  = (map_diff > MAP_MAX) ? MAP_MAX[W-1:0] : map_diff[W-1:0];
    end

    // shared multiplier: operand magnitudes, partial products, accumulate
    always_comb
    begin
        opa      = (op_reg == OP_II) ? zi_reg : zr_reg;
        opb      = (op_reg == OP_RR) ? zr_reg : zi_reg;
        mag_a    = opa[W-1] ? (~opa + W'(1)) : opa;
        mag_b    = opb[W-1] ? (~opb + W'(1)) : opb;
        part_mul = 2'(ph_reg - 3'd1);
        part_acc = 2'(ph_reg - 3'd2);
        fac_a    = part_mul[1] ? ma_reg[MW-1:HW] : ma_reg[HW-1:0];
        fac_b    = part_mul[0] ? mb_reg[MW-1:HW] : mb_reg[HW-1:0];
        prod_new = MW'(fac_a) * MW'(fac_b);
        case (part_acc)
            2'd0:    acc_add = PW'(prod_reg);
            2'd3:    acc_add = PW'(prod_reg) << MW;
            default: acc_add = PW'(prod_reg) << HW;
        endcase
    end

    // floor to Q4 and saturate
    always_comb
    begin
        if (op_reg == OP_RI)
        begin
            q_floor = acc_reg >> (FRAC_BITS - 1);
            rem_nz  = |(acc_reg & MASK_RI);
        end
        else
        begin
            q_floor = acc_reg >> FRAC_BITS;
            rem_nz  = |(acc_reg & MASK_SQ);
        end
        q_mag   = q_floor + PW'(neg_reg && rem_nz);
        q_lim   = neg_reg ? LIM_NEG : LIM_POS;
        q_sat   = (q_mag > q_lim) ? q_lim : q_mag;
        fin_res = neg_reg ? (~q_sat[W-1:0] + W'(1)) : q_sat[W-1:0];
    end

    always_comb
    begin
        mag_sum = {1'b0, rr_reg} + {1'b0, ii_reg};
        escaped = (mag_sum >= ESC_FOUR);
        zr_wide = W2'(rr_reg) - W2'(ii_reg) + W2'(cr_reg);
        zi_wide = W1'(ri_reg) + W1'(ci_reg);
        if (zr_wide > ZMAX2)
            zr_new = ZMAX2[W-1:0];
        else if (zr_wide < ZMIN2)
            zr_new = ZMIN2[W-1:0];
        else
            zr_new = zr_wide[W-1:0];
        if (zi_wide > ZMAX1)
            zi_new = ZMAX1[W-1:0];
        else if (zi_wide < ZMIN1)
            zi_new = ZMIN1[W-1:0];
        else
            zi_new = zi_wide[W-1:0];
    end

    // sequencer, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_RR;
            ph_reg        <= '0;
            cnt_reg       <= '0;
            im_sel_reg    <= 1'b0;
            k_reg         <= '0;
            inside_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            shade_reg     <= '0;
            in_set_reg    <= 1'b0;
            width_reg     <= RST_IMAGE_WIDTH;
            height_reg    <= RST_IMAGE_HEIGHT;
            max_iter_reg  <= RST_MAX_ITERATIONS;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:    width_reg    <= cfg_data[DIM_REG_W-1:0];
                    REG_IMAGE_HEIGHT:   height_reg   <= cfg_data[DIM_REG_W-1:0];
                    REG_MAX_ITERATIONS: max_iter_reg <= cfg_data[ITER_W-1:0];
                    default:            ;
                endcase
            end

            if (out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg  <= S_DIV;
                        im_sel_reg <= 1'b0;
                        cnt_reg    <= '0;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == (im_sel_reg ? LAST_IM : LAST_RE))
                        state_reg <= S_MAP;
                end
                S_MAP:
                begin
                    if (!im_sel_reg)
                    begin
                        im_sel_reg <= 1'b1;
                        cnt_reg    <= '0;
                        state_reg  <= S_DIV;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        op_reg    <= OP_RR;
                        ph_reg    <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    ph_reg <= ph_reg + 3'd1;
                    if (ph_reg == 3'd5)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    case (op_reg)
                        OP_RR:
                        begin
                            op_reg    <= OP_II;
                            ph_reg    <= '0;
                            state_reg <= S_MUL;
                        end
                        OP_II:   state_reg <= S_CHECK;
                        default: state_reg <= S_UPDATE;
                    endcase
                end
                S_CHECK:
                begin
                    if (escaped)
                    begin
                        inside_reg <= 1'b0;
                        state_reg  <= S_DONE;
                    end
                    else if (k_reg == max_iter_reg)
                    begin
                        inside_reg <= 1'b1;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        op_reg    <= OP_RI;
                        ph_reg    <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_UPDATE:
                begin
                    k_reg     <= k_reg + ITER_W'(1);
                    op_reg    <= OP_RR;
                    ph_reg    <= '0;
                    state_reg <= S_MUL;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        shade_reg     <= inside_reg ? SHADE_INSIDE : SHADE_ESCAPED;
                        in_set_reg    <= inside_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    num_reg <= NUM_W'(pixel_column) * NUM_W'(7);
                    div_reg <= eff_w;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    row_reg <= pixel_row;
                end
            end
            S_DIV:
            begin
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                rem_reg <= rem_new;
                quo_reg <= quo_new;
            end
            S_MAP:
            begin
                if (!im_sel_reg)
                begin
                    cr_reg  <= map_res;
                    num_reg <= {3'b000, row_reg, 1'b0};
                    div_reg <= eff_h;
                    rem_reg <= '0;
                    quo_reg <= '0;
                end
                else
                begin
                    ci_reg <= map_res;
                    zr_reg <= '0;
                    zi_reg <= '0;
                end
            end
            S_MUL:
            begin
                if (ph_reg == 3'd0)
                begin
                    ma_reg  <= MW'(mag_a);
                    mb_reg  <= MW'(mag_b);
                    neg_reg <= opa[W-1] ^ opb[W-1];
                    acc_reg <= '0;
                end
                if (ph_reg >= 3'd1 && ph_reg <= 3'd4)
                    prod_reg <= prod_new;
                if (ph_reg >= 3'd2)
                    acc_reg <= acc_reg + acc_add;
            end
            S_FIN:
            begin
                case (op_reg)
                    OP_RR:   rr_reg <= fin_res;
                    OP_II:   ii_reg <= fin_res;
                    default: ri_reg <= fin_res;
                endcase
            end
            S_UPDATE:
            begin
                zr_reg <= zr_new;
                zi_reg <= zi_new;
            end
            default: ;
        endcase
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after a transaction");

    a_shade_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (in_set ? shade == SHADE_INSIDE : shade == SHADE_ESCAPED))
        else $error("shade and in_set disagree");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < div_reg)
        else $error("divider remainder not below divisor");

    a_quo_capped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> quo_reg <= QUO_CAP)
        else $error("divider quotient above cap");

    a_squares_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> !rr_reg[W-1] && !ii_reg[W-1])
        else $error("negative square at escape test");

endmodule

`default_nettype wire
